### design/tprs_pkg.sv
// Shared types, codes and decode functions of the teletext packet row store.
package tprs_pkg;

  localparam int unsigned UNIT_BYTES = 46;

  localparam logic [7:0] STUFF_BYTE     = 8'hFF;
  localparam logic [5:0] POS_ADDR_HI    = 6'd4;
  localparam logic [5:0] POS_ADDR_LO    = 6'd5;
  localparam logic [5:0] POS_ROW_FIRST  = 6'd6;
  localparam logic [5:0] POS_FLAG_FIRST = 6'd8;
  localparam logic [5:0] POS_FLAG_LAST  = 6'd13;
  localparam logic [5:0] POS_LAST       = 6'(UNIT_BYTES - 1);

  typedef enum logic {
    OP_UNIT_BYTE = 1'b0,
    OP_READ      = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    KIND_STUFFING         = 4'd0,
    KIND_BAD_ADDR         = 4'd1,
    KIND_HEADER_OK        = 4'd2,
    KIND_HEADER_INACTIVE  = 4'd3,
    KIND_HEADER_BAD_FLAGS = 4'd4,
    KIND_ROW_STORED       = 4'd5,
    KIND_ROW_INACTIVE     = 4'd6,
    KIND_ROW_IGNORED      = 4'd7,
    KIND_READ_REPLY       = 4'd8
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] unit_byte;
    logic       unit_start;
    logic [4:0] read_row;
    logic [5:0] read_col;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] magazine;
    logic [4:0] row_number;
    logic [2:0] charset;
    logic       row_changed;
    logic       page_erased;
    logic [7:0] read_data;
  } out_t;

  // Row store access issued by the decoder: a plain read or a compare-and-write.
  typedef struct packed {
    logic       rd_en;
    logic       wr_cand;
    logic [4:0] row;
    logic [5:0] col;
    logic [7:0] data;
  } mem_req_t;

  // Decoded request handed to the row store stage.
  typedef struct packed {
    logic valid;
    logic start;
    logic res;
    logic use_rd;
    out_t out;
  } front_t;

  // Hamming 8/4 exact codeword decode: bit 4 set marks a bad codeword.
  function automatic logic [4:0] ham84(input logic [7:0] b);
    logic [4:0] r;
    unique case (b)
      8'hA8:   r = 5'd0;
      8'h0B:   r = 5'd1;
      8'h26:   r = 5'd2;
      8'h85:   r = 5'd3;
      8'h92:   r = 5'd4;
      8'h31:   r = 5'd5;
      8'h1C:   r = 5'd6;
      8'hBF:   r = 5'd7;
      8'h40:   r = 5'd8;
      8'hE3:   r = 5'd9;
      8'hCE:   r = 5'd10;
      8'h6D:   r = 5'd11;
      8'h7A:   r = 5'd12;
      8'hD9:   r = 5'd13;
      8'hF4:   r = 5'd14;
      8'h57:   r = 5'd15;
      default: r = 5'b1_0000;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [3:0] rev4(input logic [3:0] v);
    logic [3:0] r;
    for (int i = 0; i < 4; i++) begin
      r[i] = v[3-i];
    end
    return r;
  endfunction

endpackage

### design/tprs_unit_dec.sv
// Unit decoder: byte position, address and flag decode, magazine and charset state.
module tprs_unit_dec #(
  parameter int unsigned ROW_COUNT = 24,
  parameter int unsigned ROW_BYTES = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  tprs_pkg::in_t      in_i,
  output tprs_pkg::front_t   front_o,
  output tprs_pkg::mem_req_t mem_req_o,
  output logic               erase_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ADDR     = 8'b0000_0010,
    ST_STUFF    = 8'b0000_0100,
    ST_BADADDR  = 8'b0000_1000,
    ST_HEADER   = 8'b0001_0000,
    ST_BADFLAGS = 8'b0010_0000,
    ST_ROW      = 8'b0100_0000,
    ST_IGNORED  = 8'b1000_0000
  } unit_state_e;

  unit_state_e state_q, state_d;
  logic [5:0]  pos_q, pos_d;
  logic [7:0]  addr_q, addr_d;
  logic [23:0] flags_q, flags_d;
  logic [7:0]  active_q, active_d;
  logic [2:0]  charset_q, charset_d;

  always_comb begin
    unit_state_e st;
    logic [5:0]  p;
    logic [7:0]  an;
    logic [23:0] fw;
    logic [2:0]  idx;
    logic [4:0]  ham;
    logic [5:0]  col;
    logic [2:0]  fk;

    state_d   = state_q;
    pos_d     = pos_q;
    addr_d    = addr_q;
    flags_d   = flags_q;
    active_d  = active_q;
    charset_d = charset_q;
    front_o   = '0;
    mem_req_o = '0;
    erase_o   = 1'b0;

    ham = tprs_pkg::ham84(in_i.unit_byte);
    st  = state_q;
    p   = pos_q;
    an  = addr_q;
    fw  = flags_q;
    idx = addr_q[2:0] - 3'd1;
    col = pos_q - tprs_pkg::POS_ROW_FIRST;
    fk  = 3'(pos_q - tprs_pkg::POS_FLAG_FIRST);

    if (accept_i) begin
      if (in_i.op == tprs_pkg::OP_READ) begin
        front_o.valid          = 1'b1;
        front_o.res            = 1'b1;
        front_o.out.kind       = tprs_pkg::KIND_READ_REPLY;
        front_o.out.row_number = in_i.read_row;
        front_o.out.charset    = charset_q;
        if (({1'b0, in_i.read_row} < 6'(ROW_COUNT)) &&
            ({1'b0, in_i.read_col} < 7'(ROW_BYTES))) begin
          front_o.use_rd  = 1'b1;
          mem_req_o.rd_en = 1'b1;
          mem_req_o.row   = in_i.read_row;
          mem_req_o.col   = in_i.read_col;
        end
      end else if (in_i.unit_start || state_q != ST_IDLE) begin
        if (in_i.unit_start) begin
          st = ST_ADDR;
          p  = '0;
          an = '0;
          fw = '0;
        end
        idx = an[2:0] - 3'd1;
        col = p - tprs_pkg::POS_ROW_FIRST;
        fk  = 3'(p - tprs_pkg::POS_FLAG_FIRST);
        front_o.valid = 1'b1;
        front_o.start = in_i.unit_start;

        if (p == '0 && in_i.unit_byte == tprs_pkg::STUFF_BYTE) begin
          st = ST_STUFF;
        end

        priority if (st == ST_ADDR && p == tprs_pkg::POS_ADDR_HI) begin
          if (ham[4]) begin
            st = ST_BADADDR;
          end else begin
            an = {ham[3:0], 4'b0000};
          end
        end else if (st == ST_ADDR && p == tprs_pkg::POS_ADDR_LO) begin
          if (ham[4]) begin
            st = ST_BADADDR;
          end else begin
            an = tprs_pkg::rev8(an | {4'b0000, ham[3:0]});
            if (an[7:3] == 5'd0) begin
              st = ST_HEADER;
            end else if ({1'b0, an[7:3]} < 6'(ROW_COUNT)) begin
              st = ST_ROW;
            end else begin
              st = ST_IGNORED;
            end
          end
        end else if (st == ST_HEADER && p >= tprs_pkg::POS_FLAG_FIRST &&
                     p <= tprs_pkg::POS_FLAG_LAST) begin
          if (ham[4]) begin
            st = ST_BADFLAGS;
          end else begin
            fw[{fk, 2'b00} +: 4] = tprs_pkg::rev4(ham[3:0]);
            if (p == tprs_pkg::POS_FLAG_LAST) begin
              // Subtitle flag sets the magazine active; only then latch and erase.
              active_d[idx] = fw[15];
              if (fw[15]) begin
                charset_d = fw[23:21];
                erase_o   = fw[7];
              end
            end
          end
        end else if (st == ST_ROW && p >= tprs_pkg::POS_ROW_FIRST && active_q[idx]) begin
          if ({1'b0, col} < 7'(ROW_BYTES)) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.wr_cand = 1'b1;
            mem_req_o.row     = an[7:3];
            mem_req_o.col     = col;
            mem_req_o.data    = in_i.unit_byte;
          end
        end else begin
          st = st;
        end

        addr_d  = an;
        flags_d = fw;
        if (p < tprs_pkg::POS_LAST) begin
          pos_d   = p + 6'd1;
          state_d = st;
        end else begin
          pos_d   = '0;
          state_d = ST_IDLE;
          front_o.res            = 1'b1;
          front_o.out.magazine   = (an[2:0] != 3'd0) ? {1'b0, an[2:0]} : 4'd8;
          front_o.out.row_number = an[7:3];
          front_o.out.charset    = charset_q;
          unique case (st)
            ST_STUFF: begin
              front_o.out.kind       = tprs_pkg::KIND_STUFFING;
              front_o.out.magazine   = '0;
              front_o.out.row_number = '0;
            end
            ST_HEADER: begin
              if (active_q[idx]) begin
                front_o.out.kind        = tprs_pkg::KIND_HEADER_OK;
                front_o.out.page_erased = fw[7];
              end else begin
                front_o.out.kind = tprs_pkg::KIND_HEADER_INACTIVE;
              end
            end
            ST_BADFLAGS: front_o.out.kind = tprs_pkg::KIND_HEADER_BAD_FLAGS;
            ST_ROW: begin
              front_o.out.kind = active_q[idx] ? tprs_pkg::KIND_ROW_STORED
                                               : tprs_pkg::KIND_ROW_INACTIVE;
            end
            ST_IGNORED: front_o.out.kind = tprs_pkg::KIND_ROW_IGNORED;
            default: begin
              front_o.out.kind       = tprs_pkg::KIND_BAD_ADDR;
              front_o.out.magazine   = '0;
              front_o.out.row_number = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      addr_q    <= '0;
      flags_q   <= '0;
      active_q  <= '0;
      charset_q <= '0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      addr_q    <= addr_d;
      flags_q   <= flags_d;
      active_q  <= active_d;
      charset_q <= charset_d;
    end
  end

endmodule

### design/tprs_row_store.sv
// Row store: byte memory with compare-and-write, forwarding, erase mask and clear pass.
module tprs_row_store #(
  parameter int unsigned ROW_COUNT = 24,
  parameter int unsigned ROW_BYTES = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tprs_pkg::mem_req_t mem_req_i,
  input  logic               erase_i,
  output logic [7:0]         rd_byte_o,
  output logic               differs_o,
  output logic               busy_o
);

  localparam int unsigned DEPTH = ROW_COUNT * ROW_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(ROW_COUNT);

  logic [7:0]           mem_q [DEPTH];
  logic [7:0]           rdata_q;
  tprs_pkg::mem_req_t   s1_q;
  logic [AW-1:0]        s1_addr_q;
  logic                 fwd_q, fwd_d;
  logic [7:0]           fwd_data_q;
  logic [ROW_COUNT-1:0] first_valid_q, first_valid_d;
  logic                 clr_busy_q, clr_busy_d;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [AW-1:0]        rd_addr;
  logic [RW-1:0]        s1_row;
  logic [7:0]           stored;
  logic                 wr_en;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [7:0]           mem_wdata;

  assign rd_addr = AW'(AW'(mem_req_i.row[RW-1:0]) * AW'(ROW_BYTES)) + AW'(mem_req_i.col);
  assign s1_row  = s1_q.row[RW-1:0];

  // Column zero of an erased row reads as zero until it is written again.
  always_comb begin
    if (fwd_q) begin
      stored = fwd_data_q;
    end else if (s1_q.col == '0 && !first_valid_q[s1_row]) begin
      stored = '0;
    end else begin
      stored = rdata_q;
    end
  end

  assign differs_o = s1_q.rd_en && s1_q.wr_cand && (stored != s1_q.data);
  assign wr_en     = differs_o;
  assign rd_byte_o = stored;
  assign busy_o    = clr_busy_q;

  // A read issued while the entry is being written sees the new byte.
  assign fwd_d = mem_req_i.rd_en && s1_q.rd_en && s1_q.wr_cand && (rd_addr == s1_addr_q);

  assign mem_we    = clr_busy_q || wr_en;
  assign mem_waddr = clr_busy_q ? clr_cnt_q : s1_addr_q;
  assign mem_wdata = clr_busy_q ? 8'h00 : s1_q.data;

  always_comb begin
    first_valid_d = first_valid_q;
    if (erase_i) begin
      first_valid_d = '0;
    end else if (wr_en && s1_q.col == '0) begin
      first_valid_d[s1_row] = 1'b1;
    end
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_req_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    s1_addr_q  <= rd_addr;
    fwd_data_q <= s1_q.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q          <= '0;
      fwd_q         <= 1'b0;
      first_valid_q <= '0;
      clr_busy_q    <= 1'b1;
      clr_cnt_q     <= '0;
    end else begin
      s1_q          <= mem_req_i;
      fwd_q         <= fwd_d;
      first_valid_q <= first_valid_d;
      clr_busy_q    <= clr_busy_d;
      clr_cnt_q     <= clr_cnt_d;
    end
  end

endmodule

### design/tprs_out_buf.sv
// Two-entry result buffer between the row store stage and the output channel.
module tprs_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tprs_pkg::out_t data_i,
  output logic           valid_o,
  input  logic           stall_i,
  output tprs_pkg::out_t data_o,
  output logic [1:0]     cnt_o
);

  tprs_pkg::out_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           pop;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rd_ptr_q];
  assign cnt_o   = cnt_q;
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= 2'(cnt_q + {1'b0, push_i} - {1'b0, pop});
    end
  end

endmodule

### design/teletext_packet_row_store.sv
// Top level of the teletext packet row store.
//
// Input channel: one request per accepted edge (in_valid_i high, in_stall_o low).
// A request is either one byte of a 46-byte teletext data unit (unit_start on
// byte 0) or a read of one stored row byte. Output channel: one result per read
// request and one per completed unit, taken when out_valid_o is high and
// out_stall_i is low.
// Pipeline: a result passes the s1_q stage register and then the result
// buffer before it is offered; the row store memory read is registered, and
// the compare and write-back happen in the cycle after the read.
// Throughput: one request per cycle while in_stall_o is low, bytes of a unit back to back.
// Reset: clears unit, magazine and charset state, then sweeps the row store to
// zero, one entry per cycle, over all ROW_COUNT * ROW_BYTES entries (960 with the
// default sizes); in_stall_o stays high during the sweep.
// Stall: results queue in a two-entry buffer; in_stall_o rises when a new
// request could no longer find room there.
module teletext_packet_row_store #(
  parameter int unsigned ROW_COUNT = 24,
  parameter int unsigned ROW_BYTES = 40
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tprs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tprs_pkg::out_t out_data_o
);

  logic               accept;
  tprs_pkg::front_t   front;
  tprs_pkg::mem_req_t mem_req;
  logic               erase;
  logic [7:0]         rd_byte;
  logic               differs;
  logic               busy;
  tprs_pkg::front_t   s1_q;
  logic               cd_q, cd_d;
  tprs_pkg::out_t     result;
  logic               push;
  logic               pop;
  logic [1:0]         out_cnt;
  logic [2:0]         occupancy;

  assign accept = in_valid_i && !in_stall_o;

  // Decode the request and update unit state at the accept edge.
  tprs_unit_dec #(
    .ROW_COUNT (ROW_COUNT),
    .ROW_BYTES (ROW_BYTES)
  ) u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_i      (in_data_i),
    .front_o   (front),
    .mem_req_o (mem_req),
    .erase_o   (erase)
  );

  // Issue the memory read now; compare and write back next cycle.
  tprs_row_store #(
    .ROW_COUNT (ROW_COUNT),
    .ROW_BYTES (ROW_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .erase_i   (erase),
    .rd_byte_o (rd_byte),
    .differs_o (differs),
    .busy_o    (busy)
  );

  // Hold the decoded request alongside the row store's read stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      cd_q <= 1'b0;
    end else begin
      s1_q <= front;
      cd_q <= cd_d;
    end
  end

  // Drop the changed flag at each unit start, accumulate over its row bytes.
  assign cd_d = (s1_q.valid && s1_q.start) ? 1'b0 : (cd_q || differs);

  always_comb begin
    result = s1_q.out;
    if (s1_q.use_rd) begin
      result.read_data = rd_byte;
    end
    if (s1_q.out.kind == tprs_pkg::KIND_ROW_STORED) begin
      result.row_changed = cd_q || differs;
    end
  end

  assign push = s1_q.valid && s1_q.res;
  assign pop  = out_valid_o && !out_stall_i;

  tprs_out_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o),
    .cnt_o   (out_cnt)
  );

  // Count the buffer after this edge; a request accepted now lands next cycle.
  assign occupancy  = 3'(out_cnt) + 3'(push) - 3'(pop);
  assign in_stall_o = busy || (occupancy >= 3'd2);

  a_buf_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_cnt == 2'd2) |-> pop)
    else $error("result buffer overflow");

  a_clear_pass_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s1_q.valid)
    else $error("request in flight during row store clear pass");

  a_changed_only_stored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.row_changed) |->
      (out_data_o.kind == tprs_pkg::KIND_ROW_STORED))
    else $error("row_changed on a result that is not a stored row");

endmodule

### sim/tb.sv
// Self-checking testbench of the teletext packet row store.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_COUNT      = 24;
  localparam int ROW_BYTES      = 40;
  localparam int LAST_POS       = tprs_pkg::UNIT_BYTES - 1;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MIN_ITEMS      = 1150;
  localparam int NO_BAD_FLAG    = -1;

  // Hamming 8/4 codewords, indexed by the nibble they carry.
  localparam logic [15:0][7:0] HAM_CODES = {
    8'h57, 8'hF4, 8'hD9, 8'h7A, 8'h6D, 8'hCE, 8'hE3, 8'h40,
    8'hBF, 8'h1C, 8'h31, 8'h92, 8'h85, 8'h26, 8'h0B, 8'hA8
  };

  // Unit progress as the decoder sees it.
  typedef enum logic [2:0] {
    UNIT_IDLE,
    UNIT_ADDR,
    UNIT_STUFF,
    UNIT_BAD_ADDR,
    UNIT_HEADER,
    UNIT_BAD_FLAGS,
    UNIT_ROW,
    UNIT_IGNORED
  } unit_state_e;

  // Tracks page state, predicts results per request and checks them in order.
  class teletext_tracker;
    tprs_pkg::out_t pending_results[$];
    int             mismatches;
    unit_state_e    status;
    logic [5:0]     position;
    logic [7:0]     address;
    logic [23:0]    flag_word;
    logic           differs;
    logic           mag_active[8];
    logic [2:0]     charset;
    logic [7:0]     row_store[ROW_COUNT][ROW_BYTES];

    function new();
      mismatches = 0;
      status     = UNIT_IDLE;
      position   = '0;
      address    = '0;
      flag_word  = '0;
      differs    = 1'b0;
      charset    = '0;
      foreach (mag_active[m]) mag_active[m] = 1'b0;
      foreach (row_store[r, c]) row_store[r][c] = '0;
    endfunction

    // Exact codewords only; no single-bit correction.
    function bit decode_nibble(input logic [7:0] code, output logic [3:0] nib);
      nib = '0;
      for (int i = 0; i < 16; i++) begin
        if (HAM_CODES[i] == code) begin
          nib = 4'(i);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(input tprs_pkg::in_t req);
      tprs_pkg::out_t res;
      logic [3:0]     nib;
      logic [3:0]     flipped;
      logic [7:0]     joined;
      logic [2:0]     slot;
      logic [5:0]     col;
      logic [4:0]     row;
      res = '0;
      if (req.op == tprs_pkg::OP_READ) begin
        res.kind       = tprs_pkg::KIND_READ_REPLY;
        res.row_number = req.read_row;
        res.charset    = charset;
        if (req.read_row < ROW_COUNT && req.read_col < ROW_BYTES) begin
          res.read_data = row_store[req.read_row][req.read_col];
        end
        pending_results.push_back(res);
        return;
      end
      if (req.unit_start) begin
        position  = '0;
        status    = UNIT_ADDR;
        differs   = 1'b0;
        address   = '0;
        flag_word = '0;
      end else if (status == UNIT_IDLE) begin
        return;
      end
      // magazine 8 is carried as 0 in the low address bits
      slot = address[2:0] - 3'd1;
      if (position == 6'd0 && req.unit_byte == 8'hFF) begin
        status = UNIT_STUFF;
      end
      if (status == UNIT_ADDR && position == 6'd4) begin
        if (decode_nibble(req.unit_byte, nib)) begin
          address = {nib, 4'h0};
        end else begin
          status = UNIT_BAD_ADDR;
        end
      end else if (status == UNIT_ADDR && position == 6'd5) begin
        if (decode_nibble(req.unit_byte, nib)) begin
          joined  = {address[7:4], nib};
          address = {<<{joined}};
          row     = address[7:3];
          if (row == 5'd0) begin
            status = UNIT_HEADER;
          end else if (row < ROW_COUNT) begin
            status = UNIT_ROW;
          end else begin
            status = UNIT_IGNORED;
          end
        end else begin
          status = UNIT_BAD_ADDR;
        end
      end else if (status == UNIT_HEADER && position >= 6'd8 && position <= 6'd13) begin
        if (!decode_nibble(req.unit_byte, nib)) begin
          status = UNIT_BAD_FLAGS;
        end else begin
          flipped   = {<<{nib}};
          flag_word = flag_word | (24'(flipped) << (4 * (position - 6'd8)));
          if (position == 6'd13) begin
            mag_active[slot] = flag_word[15];
            if (flag_word[15]) begin
              charset = flag_word[23:21];
              if (flag_word[7]) begin
                for (int r = 0; r < ROW_COUNT; r++) row_store[r][0] = '0;
              end
            end
          end
        end
      end else if (status == UNIT_ROW && position >= 6'd6 && mag_active[slot]) begin
        col = position - 6'd6;
        row = address[7:3];
        if (col < ROW_BYTES && row_store[row][col] != req.unit_byte) begin
          differs             = 1'b1;
          row_store[row][col] = req.unit_byte;
        end
      end
      if (position != 6'(LAST_POS)) begin
        position++;
        return;
      end
      res.magazine   = (address[2:0] == 3'd0) ? 4'd8 : {1'b0, address[2:0]};
      res.row_number = address[7:3];
      res.charset    = charset;
      case (status)
        UNIT_STUFF: begin
          res.kind       = tprs_pkg::KIND_STUFFING;
          res.magazine   = '0;
          res.row_number = '0;
        end
        UNIT_HEADER: begin
          if (mag_active[slot]) begin
            res.kind        = tprs_pkg::KIND_HEADER_OK;
            res.page_erased = flag_word[7];
          end else begin
            res.kind = tprs_pkg::KIND_HEADER_INACTIVE;
          end
        end
        UNIT_BAD_FLAGS: res.kind = tprs_pkg::KIND_HEADER_BAD_FLAGS;
        UNIT_ROW: begin
          res.kind        = mag_active[slot] ? tprs_pkg::KIND_ROW_STORED
                                             : tprs_pkg::KIND_ROW_INACTIVE;
          res.row_changed = mag_active[slot] & differs;
        end
        UNIT_IGNORED: res.kind = tprs_pkg::KIND_ROW_IGNORED;
        default: begin
          res.kind       = tprs_pkg::KIND_BAD_ADDR;
          res.magazine   = '0;
          res.row_number = '0;
        end
      endcase
      pending_results.push_back(res);
      status   = UNIT_IDLE;
      position = '0;
    endfunction

    function string describe(input tprs_pkg::out_t r);
      return $sformatf("kind=%0d mag=%0d row=%0d charset=%0d changed=%0b erased=%0b data=%02h",
                       r.kind, r.magazine, r.row_number, r.charset, r.row_changed,
                       r.page_erased, r.read_data);
    endfunction

    function void flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endfunction

    function void check_result(input tprs_pkg::out_t got);
      tprs_pkg::out_t want;
      if (pending_results.size() == 0) begin
        flag_error({"result with nothing expected: ", describe(got)});
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.magazine !== want.magazine ||
          got.row_number !== want.row_number || got.charset !== want.charset ||
          got.row_changed !== want.row_changed || got.page_erased !== want.page_erased ||
          got.read_data !== want.read_data) begin
        flag_error({"expected ", describe(want), ", got ", describe(got)});
      end
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  tprs_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  tprs_pkg::out_t out_data;

  teletext_tracker tracker = new();

  // no idling on either side while set
  bit         calm        = 1'b0;
  int         read_mix    = 0;
  int         items_sent  = 0;
  int         idle_cycles = 0;
  logic [7:0] unit_buf [tprs_pkg::UNIT_BYTES];

  teletext_packet_row_store #(
    .ROW_COUNT (ROW_COUNT),
    .ROW_BYTES (ROW_BYTES)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Take results: stall at random, check each accepted one against the oldest prediction.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      tracker.check_result(out_data);
    end
    out_stall <= !calm && ($urandom_range(99) < 37);
  end

  // Watch for a hang: count edges where neither channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, idling first at random; hold it until it is taken.
  task automatic send_request(input tprs_pkg::in_t req);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(req);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] value, input logic start);
    tprs_pkg::in_t req;
    req.op         = tprs_pkg::OP_UNIT_BYTE;
    req.unit_byte  = value;
    req.unit_start = start;
    req.read_row   = 5'($urandom);
    req.read_col   = 6'($urandom);
    send_request(req);
  endtask

  task automatic send_read(input logic [4:0] row, input logic [5:0] col);
    tprs_pkg::in_t req;
    req.op         = tprs_pkg::OP_READ;
    req.unit_byte  = 8'($urandom);
    req.unit_start = 1'($urandom);
    req.read_row   = row;
    req.read_col   = col;
    send_request(req);
  endtask

  // Mostly inside the store, sometimes anywhere the fields reach.
  task automatic send_random_read();
    if ($urandom_range(3) != 0) begin
      send_read(5'($urandom_range(ROW_COUNT - 1)), 6'($urandom_range(ROW_BYTES - 1)));
    end else begin
      send_read(5'($urandom), 6'($urandom));
    end
  endtask

  // Fill unit_buf with a unit of random content carrying the given address and header flags.
  function automatic void build_unit(input logic [3:0] mag, input logic [4:0] row,
                                     input logic [23:0] flags);
    logic [7:0] addr;
    logic [7:0] raw;
    logic [3:0] nib;
    logic [3:0] flipped;
    for (int i = 0; i < tprs_pkg::UNIT_BYTES; i++) unit_buf[i] = 8'($urandom);
    if (unit_buf[0] == 8'hFF) begin
      unit_buf[0] = 8'h55;
    end
    addr        = {row, mag[2:0]};
    raw         = {<<{addr}};
    unit_buf[4] = HAM_CODES[raw[7:4]];
    unit_buf[5] = HAM_CODES[raw[3:0]];
    if (row == 5'd0) begin
      for (int k = 0; k < 6; k++) begin
        nib             = flags[4 * k +: 4];
        flipped         = {<<{nib}};
        unit_buf[8 + k] = HAM_CODES[flipped];
      end
    end
  endfunction

  function automatic logic [7:0] bad_code();
    logic [7:0] code;
    logic [3:0] nib;
    do begin
      code = 8'($urandom);
    end while (tracker.decode_nibble(code, nib));
    return code;
  endfunction

  function automatic logic [4:0] pick_row();
    if ($urandom_range(99) < 80) begin
      return 5'($urandom_range(ROW_COUNT - 1, 1));
    end
    return 5'($urandom);
  endfunction

  // Send the first bytes of unit_buf, with reads slipped in between at the current mix.
  task automatic send_unit(input int length);
    for (int i = 0; i < length; i++) begin
      if ($urandom_range(99) < read_mix) begin
        send_random_read();
      end
      send_byte(unit_buf[i], i == 0);
    end
  endtask

  task automatic send_header(input logic [3:0] mag, input bit sub, input bit erase,
                             input logic [2:0] cs, input int bad_flag);
    logic [23:0] flags;
    flags        = 24'($urandom);
    flags[15]    = sub;
    flags[7]     = erase;
    flags[23:21] = cs;
    build_unit(mag, 5'd0, flags);
    if (bad_flag != NO_BAD_FLAG) begin
      unit_buf[8 + bad_flag] = bad_code();
    end
    send_unit(tprs_pkg::UNIT_BYTES);
  endtask

  // keep: 0 fresh content, 1 exact copy of the stored row, 2 copy with one byte changed.
  task automatic send_row(input logic [3:0] mag, input logic [4:0] row, input int keep);
    build_unit(mag, row, 24'($urandom));
    if (keep != 0 && row < ROW_COUNT) begin
      for (int c = 0; c < ROW_BYTES; c++) unit_buf[6 + c] = tracker.row_store[row][c];
      if (keep == 2) begin
        unit_buf[6 + $urandom_range(ROW_BYTES - 1)] = 8'($urandom);
      end
    end
    send_unit(tprs_pkg::UNIT_BYTES);
  endtask

  // Hold the sender until the block has handed back everything owed.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_scenario();
    int         pick;
    logic [3:0] mag;
    pick = $urandom_range(99);
    mag  = 4'($urandom_range(8, 1));
    if (pick < 55) begin
      // well-formed page: header, then a few rows of the same magazine
      send_header(mag, $urandom_range(99) < 85, $urandom_range(99) < 20, 3'($urandom),
                  NO_BAD_FLAG);
      repeat ($urandom_range(4, 1)) send_row(mag, pick_row(), $urandom_range(2));
    end else if (pick < 67) begin
      send_row(mag, pick_row(), $urandom_range(2));
    end else if (pick < 73) begin
      build_unit(mag, pick_row(), 24'($urandom));
      unit_buf[0] = 8'hFF;
      send_unit(tprs_pkg::UNIT_BYTES);
    end else if (pick < 79) begin
      build_unit(mag, pick_row(), 24'($urandom));
      unit_buf[$urandom_range(5, 4)] = bad_code();
      send_unit(tprs_pkg::UNIT_BYTES);
    end else if (pick < 85) begin
      send_header(mag, 1'b1, 1'($urandom), 3'($urandom), $urandom_range(5));
    end else if (pick < 91) begin
      // cut short; the next start abandons it, stray bytes may carry it on
      build_unit(mag, pick_row(), 24'($urandom));
      send_unit($urandom_range(LAST_POS, 1));
    end else if (pick < 95) begin
      repeat ($urandom_range(5, 1)) send_byte(8'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(6, 1)) send_random_read();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Read the cleared store at its corners and past its ends.
    send_read(5'd0, 6'd0);
    send_read(5'd23, 6'd39);
    send_read(5'd24, 6'd0);
    send_read(5'd0, 6'd40);
    send_read(5'd31, 6'd63);
    // Drop a byte that arrives with no unit open.
    send_byte(8'hFF, 1'b0);
    // Stuffing unit.
    build_unit(4'd1, 5'd1, '0);
    unit_buf[0] = 8'hFF;
    send_unit(tprs_pkg::UNIT_BYTES);
    // Bad address codeword in either nibble.
    build_unit(4'd2, 5'd3, '0);
    unit_buf[4] = bad_code();
    send_unit(tprs_pkg::UNIT_BYTES);
    build_unit(4'd2, 5'd3, '0);
    unit_buf[5] = bad_code();
    send_unit(tprs_pkg::UNIT_BYTES);
    // Row of a magazine never activated.
    send_row(4'd3, 5'd5, 0);
    // Header with no flags set leaves the magazine inactive.
    build_unit(4'd3, 5'd0, 24'h000000);
    send_unit(tprs_pkg::UNIT_BYTES);
    // Run the next stretch with no idling on either side.
    calm = 1'b1;
    // Activate magazine 8 with charset 7, then store rows into it.
    send_header(4'd8, 1'b1, 1'b0, 3'd7, NO_BAD_FLAG);
    send_row(4'd8, 5'd1, 0);
    send_row(4'd8, 5'd1, 1);
    build_unit(4'd8, 5'd23, '0);
    for (int c = 0; c < ROW_BYTES; c++) unit_buf[6 + c] = 8'hFF;
    send_unit(tprs_pkg::UNIT_BYTES);
    build_unit(4'd8, 5'd22, '0);
    for (int c = 0; c < ROW_BYTES; c++) unit_buf[6 + c] = 8'h00;
    send_unit(tprs_pkg::UNIT_BYTES);
    // Rows past the store are ignored, including the all-ones address.
    send_row(4'd8, 5'd24, 0);
    send_row(4'd7, 5'd31, 0);
    calm = 1'b0;
    // Header with a bad flag nibble at the first and at the last flag byte.
    send_header(4'd8, 1'b1, 1'b1, 3'd2, 0);
    send_header(4'd8, 1'b1, 1'b1, 3'd2, 5);
    // Every flag set: erase the page, latch charset 7.
    build_unit(4'd8, 5'd0, 24'hFFFFFF);
    send_unit(tprs_pkg::UNIT_BYTES);
    send_read(5'd1, 6'd0);
    send_read(5'd23, 6'd1);
    // Erase with charset 0.
    send_header(4'd8, 1'b1, 1'b1, 3'd0, NO_BAD_FLAG);
    // Read while a row is being written.
    read_mix = 50;
    send_row(4'd8, 5'd2, 0);
    read_mix = 0;
    // Abandon a unit by starting another.
    build_unit(4'd8, 5'd3, '0);
    send_unit(20);
    send_row(4'd8, 5'd3, 2);
    // Deactivate magazine 8, hit it with a row, then bring it back.
    send_header(4'd8, 1'b0, 1'b1, 3'd5, NO_BAD_FLAG);
    send_row(4'd8, 5'd4, 0);
    send_header(4'd8, 1'b1, 1'b0, 3'd4, NO_BAD_FLAG);

    // Drain everything owed, then finish with random pages and noise.
    hold_until_drained();
    read_mix = 6;
    while (items_sent < MIN_ITEMS) begin
      run_random_scenario();
    end

    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
